// ----- src/lpfs_pkg.sv -----
// Package for the length-prefixed frame splitter.
// Types, codes and sizing constants shared by the core and top level.
`default_nettype none

package lpfs_pkg;

  // Width of the body length counters; a body never exceeds 2^LEN_BITS bytes.
  localparam int LEN_BITS   = 24;
  localparam int HDR_BYTES  = 8;
  localparam int FLD_BYTES  = 4;            // bytes per header length field
  localparam int CNT_W      = 3;            // header byte counter
  localparam int FLD_W      = 8 * FLD_BYTES;
  localparam int CFG_W      = 25;
  localparam int CMP_W      = 33;           // holds 2^LEN_BITS and any cfg value
  localparam logic [CFG_W-1:0] MAX_RESET = CFG_W'(16777216);

  typedef logic [LEN_BITS-1:0] len_t;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_FILE    = 2'd2,
    PH_SKIP    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_TOTAL = 2'd1,
    ST_PAY_LONG  = 2'd2
  } status_t;

  localparam logic SEC_PAYLOAD = 1'b0;
  localparam logic SEC_FILE    = 1'b1;

  // One result of the deframer.
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       byte_valid;
    logic       section;
    logic       section_last;
    logic       frame_end;
    status_t    status;
  } res_t;

endpackage

`default_nettype wire

// ----- src/lpfs_core.sv -----
// Deframer state machine: header capture, length checks and body counters.
// Depends on lpfs_pkg. Produces at most one result per accepted byte.
`default_nettype none

module lpfs_core
  import lpfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_fire,
  input  wire logic [7:0]       in_byte,
  input  wire logic [CFG_W-1:0] max_frame,
  output res_t                  res
);

  phase_t               phase_r, phase_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FLD_W-1:0]     shift_r, shift_nxt;
  logic [FLD_W-1:0]     total_r, total_nxt;
  logic [FLD_W-1:0]     body_r, body_nxt;     // total - 8, wraps if total < 8
  logic                 lt8_r, lt8_nxt;
  len_t                 pay_left_r, pay_left_nxt;
  len_t                 file_left_r, file_left_nxt;
  len_t                 skip_left_r, skip_left_nxt;

  logic [FLD_W-1:0]     cur_fld;
  logic [FLD_W-1:0]     file_bytes;
  logic [CMP_W-1:0]     cap;
  logic [CMP_W-1:0]     limit;
  logic                 bad_total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      cnt_r       <= '0;
      shift_r     <= '0;
      total_r     <= '0;
      body_r      <= '0;
      lt8_r       <= 1'b0;
      pay_left_r  <= '0;
      file_left_r <= '0;
      skip_left_r <= '0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      shift_r     <= shift_nxt;
      total_r     <= total_nxt;
      body_r      <= body_nxt;
      lt8_r       <= lt8_nxt;
      pay_left_r  <= pay_left_nxt;
      file_left_r <= file_left_nxt;
      skip_left_r <= skip_left_nxt;
    end
  end

  // Field completed by this byte: total on the 4th byte, payload on the 8th.
  assign cur_fld    = {shift_r[FLD_W-9:0], in_byte};
  assign file_bytes = body_r - cur_fld;
  assign cap        = CMP_W'(1) << LEN_BITS;
  assign limit      = (CMP_W'(max_frame) > cap) ? cap : CMP_W'(max_frame);
  assign bad_total  = lt8_r || (CMP_W'(total_r) > limit);

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    shift_nxt     = shift_r;
    total_nxt     = total_r;
    body_nxt      = body_r;
    lt8_nxt       = lt8_r;
    pay_left_nxt  = pay_left_r;
    file_left_nxt = file_left_r;
    skip_left_nxt = skip_left_r;
    res           = '0;

    if (in_fire) begin
      case (phase_r)
        PH_HEADER: begin
          shift_nxt = cur_fld;
          if (cnt_r == CNT_W'(HDR_BYTES - 1)) begin
            cnt_nxt = '0;
            if (bad_total) begin
              res.valid     = 1'b1;
              res.frame_end = 1'b1;
              res.status    = ST_BAD_TOTAL;
            end else if (cur_fld > body_r) begin
              if (body_r == '0) begin
                res.valid     = 1'b1;
                res.frame_end = 1'b1;
                res.status    = ST_PAY_LONG;
              end else begin
                skip_left_nxt = body_r[LEN_BITS-1:0];
                phase_nxt     = PH_SKIP;
              end
            end else begin
              pay_left_nxt  = cur_fld[LEN_BITS-1:0];
              file_left_nxt = file_bytes[LEN_BITS-1:0];
              if (cur_fld != '0) begin
                phase_nxt = PH_PAYLOAD;
              end else if (file_bytes != '0) begin
                phase_nxt = PH_FILE;
              end else begin
                res.valid     = 1'b1;
                res.frame_end = 1'b1;
                res.status    = ST_GOOD;
              end
            end
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
            if (cnt_r == CNT_W'(FLD_BYTES - 1)) begin
              total_nxt = cur_fld;
              body_nxt  = cur_fld - FLD_W'(HDR_BYTES);
              lt8_nxt   = cur_fld < FLD_W'(HDR_BYTES);
            end
          end
        end
        PH_PAYLOAD: begin
          pay_left_nxt     = pay_left_r - LEN_BITS'(1);
          res.valid        = 1'b1;
          res.data         = in_byte;
          res.byte_valid   = 1'b1;
          res.section      = SEC_PAYLOAD;
          if (pay_left_r == LEN_BITS'(1)) begin
            res.section_last = 1'b1;
            if (file_left_r != '0) begin
              phase_nxt = PH_FILE;
            end else begin
              res.frame_end = 1'b1;
              phase_nxt     = PH_HEADER;
            end
          end
        end
        PH_FILE: begin
          file_left_nxt    = file_left_r - LEN_BITS'(1);
          res.valid        = 1'b1;
          res.data         = in_byte;
          res.byte_valid   = 1'b1;
          res.section      = SEC_FILE;
          if (file_left_r == LEN_BITS'(1)) begin
            res.section_last = 1'b1;
            res.frame_end    = 1'b1;
            phase_nxt        = PH_HEADER;
          end
        end
        PH_SKIP: begin
          skip_left_nxt = skip_left_r - LEN_BITS'(1);
          if (skip_left_r == LEN_BITS'(1)) begin
            res.valid     = 1'b1;
            res.frame_end = 1'b1;
            res.status    = ST_PAY_LONG;
            phase_nxt     = PH_HEADER;
          end
        end
        default: begin
          phase_nxt = PH_HEADER;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/length_prefixed_frame_splitter_top.sv -----
// A result appears on out_* the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_tready is high; each byte costs one counter step or one
// header compare in lpfs_core. in_tready drops only while a result waits in
// the output register and out_tready is low. Reset (rst_n low, synchronous)
// returns to header search, clears all counters, empties the output and sets
// max_frame_bytes to 2^24.
// Top level: stream ports, configuration register, output register.
// Depends on lpfs_pkg and lpfs_core.
`default_nettype none

module length_prefixed_frame_splitter_top
  import lpfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output      logic             in_tready,
  input  wire logic [7:0]       in_tdata,   // [7:0] data_byte
  output      logic             out_tvalid,
  input  wire logic             out_tready,
  output      logic [15:0]      out_tdata,  // [7:0] out_byte, [9:8] status
  output      logic [2:0]       out_tuser,  // [0] byte_valid, [1] section, [2] section_last
  output      logic             out_tlast,  // frame_end
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data    // max_frame_bytes
);

  logic [CFG_W-1:0] max_r;
  logic             out_valid_r;
  res_t             res;
  res_t             res_r;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= MAX_RESET;
    end else if (cfg_valid) begin
      max_r <= cfg_data;
    end
  end

  lpfs_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_byte   (in_tdata),
    .max_frame (max_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload register needs no reset; it loads only when a new result forms.
  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, res_r.status, res_r.data};
  assign out_tuser  = {res_r.section_last, res_r.section, res_r.byte_valid};
  assign out_tlast  = res_r.frame_end;

endmodule

`default_nettype wire

// ----- src/lpfs_checker.sv -----
// Port-level checks for the frame splitter, bound to the top level.
// Sees only the top level's ports; no package needed.
`default_nettype none

module lpfs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  // A held result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
                                  && $stable(out_tlast))
    else $error("result changed while stalled");

  // Results without a body byte are frame status only.
  a_status_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && out_tdata[7:0] == 8'd0
                                    && out_tuser[2:1] == 2'b00)
    else $error("non-byte result without frame end");

  // Error statuses never ride on a body byte, and code three never appears.
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9:8] != 2'd0 |-> !out_tuser[0] && out_tlast
                                             && out_tdata[9:8] != 2'd3)
    else $error("bad status on result");

  // A good frame closing on a byte closes its section too.
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tuser[0] |-> out_tuser[2])
    else $error("frame end without section end");

  // Output is empty right after reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind length_prefixed_frame_splitter_top lpfs_checker u_lpfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
